// ===== design/svmsc_pkg.sv =====
package svmsc_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int GAIN_W      = 16;
	localparam int OUT_W       = 16;
	localparam int TALLY_W     = 7;
	localparam int ACC_W       = 38;
	localparam int PSUM_W      = 33;
	localparam int DIGIT_W     = 4;
	localparam int UNITY_SHIFT = 29;
	localparam int QUO_W       = 15;
	localparam int MAX_VOICES_DEF = 64;
	localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(32768);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic [GAIN_W-1:0]          left_gain;
		logic [GAIN_W-1:0]          right_gain;
		logic                       last_voice;
	} voice_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] left_out;
		logic signed [OUT_W-1:0] right_out;
		logic [TALLY_W-1:0]      voices_mixed;
	} mix_t;

endpackage

// ===== design/svmsc_clip.sv =====
module svmsc_clip import svmsc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] acc,
	output logic                    done,
	output logic signed [OUT_W-1:0] result
);

	localparam int NUM_W = ACC_W + QUO_W;
	localparam int DIV_W = ACC_W + 1;
	localparam int CNT_W = $clog2(QUO_W);

	typedef enum logic [1:0] {IDLE, PREP, DIV} state_t;

	state_t                  state_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        mag_q;
	logic [DIV_W-1:0]        rem_q;
	logic [DIV_W-1:0]        den_q;
	logic [QUO_W-1:0]        nlo_q;
	logic [QUO_W-1:0]        quo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic signed [OUT_W-1:0] result_q;

	logic [ACC_W-1:0] abs_acc;
	logic [NUM_W-1:0] num;
	logic [DIV_W-1:0] den;
	logic             below_unity;
	logic [DIV_W:0]   rem2;
	logic [DIV_W:0]   diff;
	logic             ge;
	logic [QUO_W-1:0] q_next;

	function automatic logic signed [OUT_W-1:0] apply_sign(logic neg, logic [QUO_W-1:0] m);
		logic [OUT_W-1:0] w;
		w = {{(OUT_W-QUO_W){1'b0}}, m};
		return neg ? $signed(-w) : $signed(w);
	endfunction

	assign abs_acc     = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
	assign num         = {mag_q, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, mag_q};
	assign den         = {1'b0, mag_q} + (DIV_W'(1) << UNITY_SHIFT);
	assign below_unity = mag_q <= (ACC_W'(1) << UNITY_SHIFT);
	assign rem2        = {rem_q, nlo_q[QUO_W-1]};
	assign ge          = rem2 >= {1'b0, den_q};
	assign diff        = rem2 - {1'b0, den_q};
	assign q_next      = {quo_q[QUO_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (start) begin
						neg_q   <= acc[ACC_W-1];
						mag_q   <= abs_acc;
						done_q  <= 1'b0;
						state_q <= PREP;
					end
				end
				PREP: begin
					if (below_unity) begin
						result_q <= apply_sign(neg_q,
							num[UNITY_SHIFT+QUO_W-1:UNITY_SHIFT]);
						done_q   <= 1'b1;
						state_q  <= IDLE;
					end else begin
						rem_q   <= {1'b0, num[NUM_W-1:QUO_W]};
						nlo_q   <= num[QUO_W-1:0];
						den_q   <= den;
						quo_q   <= '0;
						cnt_q   <= CNT_W'(QUO_W - 1);
						state_q <= DIV;
					end
				end
				DIV: begin
					rem_q <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
					nlo_q <= {nlo_q[QUO_W-2:0], 1'b0};
					quo_q <= q_next;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						result_q <= apply_sign(neg_q, q_next);
						done_q   <= 1'b1;
						state_q  <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== design/stereo_voice_mixer_soft_clip.sv =====
// Channel  Handshake            Word
// voice    voice_valid/stall    voice_t: two samples, two gains, last_voice
// mix      mix_valid/stall      mix_t: two clipped samples, voice count
//
// A voice word is taken in IDLE, then the MAC state passes the gains four bits a cycle into
// the products; a word beyond the voice limit is dropped.
// Closing a frame scales a clip at or below full scale directly, or else runs the
// one-bit-a-cycle divider (15 quotient bits); both channels clip in parallel.
// The mix word sits in an output register; the next frame is taken while it waits,
// and a close holds until that register is free.
// Reset clears the accumulators, the tally and mix_valid, and leaves voice_stall low.
module stereo_voice_mixer_soft_clip import svmsc_pkg::*; #(
	parameter int MAX_VOICES = MAX_VOICES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   voice_valid,
	output logic   voice_stall,
	input  voice_t voice,
	output logic   mix_valid,
	input  logic   mix_stall,
	output mix_t   mix
);

	localparam int DIG_CNT_W = $clog2(GAIN_W / DIGIT_W);

	typedef enum logic [1:0] {IDLE, MAC, CLIP} state_t;

	state_t                   state_q;
	logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;
	logic [TALLY_W-1:0]       tally_q;
	logic signed [SAMPLE_W-1:0] smp_l_s1, smp_r_s1;
	logic [GAIN_W-1:0]        gain_l_s1, gain_r_s1;
	logic signed [PSUM_W-1:0] psum_l_s1, psum_r_s1;
	logic [DIG_CNT_W-1:0]     digit_s1;
	logic                     last_s1;
	logic                     clip_start_q;
	logic                     mix_valid_q;
	mix_t                     mix_q;

	logic signed [PSUM_W-1:0] psum_l_next, psum_r_next;
	logic                     done_l, done_r;
	logic signed [OUT_W-1:0]  clip_l, clip_r;
	logic                     accept, room, finish;

	function automatic logic [GAIN_W-1:0] sat_gain(logic [GAIN_W-1:0] g);
		return (g > GAIN_MAX) ? GAIN_MAX : g;
	endfunction

	function automatic logic signed [PSUM_W-1:0] step(logic signed [PSUM_W-1:0] p,
		logic signed [SAMPLE_W-1:0] s, logic [DIGIT_W-1:0] d);
		logic signed [SAMPLE_W+DIGIT_W:0] prod;
		prod = s * $signed({1'b0, d});
		return (p <<< DIGIT_W) + PSUM_W'(prod);
	endfunction

	assign psum_l_next = step(psum_l_s1, smp_l_s1, gain_l_s1[GAIN_W-1 -: DIGIT_W]);
	assign psum_r_next = step(psum_r_s1, smp_r_s1, gain_r_s1[GAIN_W-1 -: DIGIT_W]);

	assign voice_stall = (state_q != IDLE);
	assign accept      = voice_valid && !voice_stall;
	assign room        = !mix_valid_q || !mix_stall;
	assign finish      = (state_q == CLIP) && !clip_start_q && done_l && done_r && room;

	svmsc_clip u_clip_l (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (clip_start_q),
		.acc    (acc_l_q),
		.done   (done_l),
		.result (clip_l)
	);

	svmsc_clip u_clip_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (clip_start_q),
		.acc    (acc_r_q),
		.done   (done_r),
		.result (clip_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			acc_l_q      <= '0;
			acc_r_q      <= '0;
			tally_q      <= '0;
			clip_start_q <= 1'b0;
			mix_valid_q  <= 1'b0;
		end else begin
			clip_start_q <= 1'b0;
			if (mix_valid_q && !mix_stall)
				mix_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						smp_l_s1  <= voice.left_sample;
						smp_r_s1  <= voice.right_sample;
						gain_l_s1 <= sat_gain(voice.left_gain);
						gain_r_s1 <= sat_gain(voice.right_gain);
						psum_l_s1 <= '0;
						psum_r_s1 <= '0;
						digit_s1  <= '0;
						last_s1   <= voice.last_voice;
						if (32'(tally_q) < MAX_VOICES) begin
							state_q <= MAC;
						end else if (voice.last_voice) begin
							clip_start_q <= 1'b1;
							state_q      <= CLIP;
						end
					end
				end
				MAC: begin
					psum_l_s1 <= psum_l_next;
					psum_r_s1 <= psum_r_next;
					gain_l_s1 <= gain_l_s1 << DIGIT_W;
					gain_r_s1 <= gain_r_s1 << DIGIT_W;
					digit_s1  <= digit_s1 + 1'b1;
					if (digit_s1 == '1) begin
						acc_l_q <= acc_l_q + ACC_W'(psum_l_next);
						acc_r_q <= acc_r_q + ACC_W'(psum_r_next);
						tally_q <= tally_q + 1'b1;
						if (last_s1) begin
							clip_start_q <= 1'b1;
							state_q      <= CLIP;
						end else begin
							state_q <= IDLE;
						end
					end
				end
				CLIP: begin
					if (finish) begin
						mix_q.left_out     <= clip_l;
						mix_q.right_out    <= clip_r;
						mix_q.voices_mixed <= tally_q;
						mix_valid_q        <= 1'b1;
						acc_l_q            <= '0;
						acc_r_q            <= '0;
						tally_q            <= '0;
						state_q            <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign mix_valid = mix_valid_q;
	assign mix       = mix_q;

endmodule

// ===== design/svmsc_checker.sv =====
module svmsc_checker import svmsc_pkg::*; #(
	parameter int MAX_VOICES = MAX_VOICES_DEF
) (
	input logic   clk,
	input logic   arst_n,
	input logic   voice_valid,
	input logic   voice_stall,
	input voice_t voice,
	input logic   mix_valid,
	input logic   mix_stall,
	input mix_t   mix
);

	a_mix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && mix_stall |=> mix_valid)
		else $error("mix word dropped while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid |-> mix.voices_mixed != '0 && 32'(mix.voices_mixed) <= MAX_VOICES)
		else $error("voice count out of range");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid |-> mix.left_out != 16'sh8000 && mix.right_out != 16'sh8000)
		else $error("clipped sample beyond full scale");

	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		voice_valid && !voice_stall && voice.last_voice |=> voice_stall)
		else $error("frame close not followed by busy");

	a_new_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mix_valid) |-> $past(voice_stall))
		else $error("mix word without a closed frame");

endmodule

bind stereo_voice_mixer_soft_clip svmsc_checker #(.MAX_VOICES(MAX_VOICES)) u_chk (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import svmsc_pkg::*;

	localparam int      RANDOM_ITEMS = 1750;
	localparam int      LONG_HOLD    = 600;
	localparam int      TAIL_CYCLES  = 40;
	localparam int      DRAIN_LIMIT  = 20000;
	localparam longint  FULL_SCALE   = 32767;
	localparam longint  UNITY_MAG    = 64'd1 << UNITY_SHIFT;

	typedef struct {
		voice_t word;
		int     reps;
		bit     typed;
		mix_t   want;
	} stim_row_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   voice_valid = 1'b0;
	logic   voice_stall;
	voice_t voice = '0;
	logic   mix_valid;
	logic   mix_stall = 1'b0;
	mix_t   mix;

	stereo_voice_mixer_soft_clip dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.voice_valid (voice_valid),
		.voice_stall (voice_stall),
		.voice       (voice),
		.mix_valid   (mix_valid),
		.mix_stall   (mix_stall),
		.mix         (mix)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic signed [ACC_W-1:0] left_sum = '0;
	logic signed [ACC_W-1:0] right_sum = '0;
	logic [TALLY_W-1:0]      frame_voices = '0;
	bit                      frame_dropped = 1'b0;
	mix_t                    mix_due[$];
	stim_row_t               directed_rows[$];

	int fails = 0;
	int voices_offered = 0;
	int frames_closed = 0;
	int frames_clipped = 0;
	int frames_overfull = 0;
	int mixes_seen = 0;
	bit steady = 1'b0;
	bit long_hold_req = 1'b0;

	function automatic logic [OUT_W-1:0] soft_limit(input logic signed [ACC_W-1:0] sum);
		logic signed [63:0] wide;
		logic [63:0]        mag;
		bit                 neg;
		wide = sum;
		neg = wide < 0;
		mag = neg ? -wide : wide;
		if (mag <= UNITY_MAG)
			mag = (mag * FULL_SCALE) >> UNITY_SHIFT;
		else
			mag = (mag * FULL_SCALE) / (UNITY_MAG + mag);
		if (mag > FULL_SCALE)
			mag = FULL_SCALE;
		return neg ? -mag[OUT_W-1:0] : mag[OUT_W-1:0];
	endfunction

	task automatic mix_voice(input voice_t w, input bit typed, input mix_t want);
		logic signed [63:0] prod_l, prod_r;
		logic [GAIN_W-1:0]  gl, gr;
		mix_t               pred;
		gl = (w.left_gain > GAIN_MAX) ? GAIN_MAX : w.left_gain;
		gr = (w.right_gain > GAIN_MAX) ? GAIN_MAX : w.right_gain;
		if (frame_voices < TALLY_W'(MAX_VOICES_DEF)) begin
			prod_l = w.left_sample;
			prod_r = w.right_sample;
			prod_l = prod_l * $signed({48'd0, gl});
			prod_r = prod_r * $signed({48'd0, gr});
			left_sum = left_sum + prod_l[ACC_W-1:0];
			right_sum = right_sum + prod_r[ACC_W-1:0];
			frame_voices = frame_voices + 1'b1;
		end else begin
			frame_dropped = 1'b1;
		end
		if (w.last_voice) begin
			pred.left_out = soft_limit(left_sum);
			pred.right_out = soft_limit(right_sum);
			pred.voices_mixed = frame_voices;
			mix_due.push_back(typed ? want : pred);
			frames_closed++;
			if (left_sum > UNITY_MAG || left_sum < -UNITY_MAG ||
					right_sum > UNITY_MAG || right_sum < -UNITY_MAG)
				frames_clipped++;
			if (frame_dropped)
				frames_overfull++;
			left_sum = '0;
			right_sum = '0;
			frame_voices = '0;
			frame_dropped = 1'b0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 4))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'hffff;
				3: return 16'h0000;
				default: return 16'h0001;
			endcase
		end
		if (r < 65)
			return SAMPLE_W'($urandom_range(0, 65535));
		return SAMPLE_W'($urandom_range(0, 4095) - 2048);
	endfunction

	function automatic logic [GAIN_W-1:0] random_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return GAIN_W'($urandom_range(0, 65535));
		if (r < 25)
			return GAIN_MAX;
		if (r < 45)
			return GAIN_W'(16384);
		return GAIN_W'($urandom_range(0, 32768));
	endfunction

	function automatic voice_t random_voice(input bit last);
		voice_t w;
		w.left_sample = random_sample();
		w.right_sample = random_sample();
		w.left_gain = random_gain();
		w.right_gain = random_gain();
		w.last_voice = last;
		return w;
	endfunction

	function automatic int frame_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 4);
		if (r < 90)
			return $urandom_range(5, 16);
		if (r < 97)
			return $urandom_range(17, 63);
		return $urandom_range(64, 72);
	endfunction

	task automatic add_row(input int ls, input int rs, input int lg, input int rg,
			input bit last, input int reps, input bit typed,
			input int lo, input int ro, input int vm);
		stim_row_t row;
		row.word.left_sample = ls[SAMPLE_W-1:0];
		row.word.right_sample = rs[SAMPLE_W-1:0];
		row.word.left_gain = lg[GAIN_W-1:0];
		row.word.right_gain = rg[GAIN_W-1:0];
		row.word.last_voice = last;
		row.reps = reps;
		row.typed = typed;
		row.want.left_out = lo[OUT_W-1:0];
		row.want.right_out = ro[OUT_W-1:0];
		row.want.voices_mixed = vm[TALLY_W-1:0];
		directed_rows.push_back(row);
	endtask

	task automatic offer_voice(input voice_t w, input bit typed, input mix_t want);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			voice_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		voice <= w;
		voice_valid <= 1'b1;
		@(posedge clk);
		// hold the word until taken
		while (voice_stall)
			@(posedge clk);
		voices_offered++;
		mix_voice(w, typed, want);
	endtask

	task automatic show_mismatch(input string what, input int exp_val, input int got_val);
		fails++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got_val);
	endtask

	initial begin : mix_sink
		int   stall_left;
		mix_t due;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (mix_valid && !mix_stall) begin
				mixes_seen++;
				if (mix_due.size() == 0) begin
					fails++;
					$display("%0t: unexpected mix word, left %0d right %0d voices %0d",
						$time, mix.left_out, mix.right_out, mix.voices_mixed);
				end else begin
					due = mix_due.pop_front();
					if (mix.left_out !== due.left_out)
						show_mismatch("left_out", due.left_out, mix.left_out);
					if (mix.right_out !== due.right_out)
						show_mismatch("right_out", due.right_out, mix.right_out);
					if (mix.voices_mixed !== due.voices_mixed)
						show_mismatch("voices_mixed", due.voices_mixed, mix.voices_mixed);
				end
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				mix_stall <= 1'b1;
				stall_left--;
			end else begin
				mix_stall <= 1'b0;
				if (!steady)
					stall_left = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int        k, len, frame, drain;
		stim_row_t row;

		add_row(0, 0, 16384, 16384, 1, 1, 1, 0, 0, 1);
		add_row(32767, -32768, 16384, 16384, 1, 1, 1, 32766, -32767, 1);
		add_row(16384, 16384, 32768, 32768, 1, 1, 1, 32767, 32767, 1);
		add_row(-32768, 32767, 32768, 32768, 1, 1, 1, -21844, 21844, 1);
		add_row(-32768, 32767, 65535, 32769, 1, 1, 1, -21844, 21844, 1);
		add_row(32767, -32768, 0, 0, 1, 1, 1, 0, 0, 1);
		// just past full scale on both channels
		add_row(-32768, 16384, 16384, 32768, 0, 1, 0, 0, 0, 0);
		add_row(-1, 1, 1, 1, 1, 1, 0, 0, 0, 0);
		add_row(12000, -7000, 20000, 9000, 0, 1, 0, 0, 0, 0);
		add_row(-31000, 25000, 5000, 30000, 0, 1, 0, 0, 0, 0);
		add_row(8191, -8192, 16384, 16384, 0, 1, 0, 0, 0, 0);
		add_row(-1, 1, 40000, 65535, 1, 1, 0, 0, 0, 0);
		// exactly the voice limit
		add_row(1000, -1000, 16384, 16384, 0, 63, 0, 0, 0, 0);
		add_row(1000, -1000, 16384, 16384, 1, 1, 0, 0, 0, 0);
		// over the voice limit, closing word dropped too
		add_row(32767, -32768, 32768, 32768, 0, 70, 0, 0, 0, 0);
		add_row(32767, -32768, 32768, 32768, 1, 1, 0, 0, 0, 0);
		add_row(100, -100, 16384, 16384, 1, 1, 1, 99, -99, 1);
		add_row(-32768, -32768, 65535, 65535, 0, 1, 0, 0, 0, 0);
		add_row(32767, 32767, 65535, 65535, 1, 1, 0, 0, 0, 0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			for (k = 0; k < row.reps; k++)
				offer_voice(row.word, row.typed, row.want);
		end

		frame = 0;
		voices_offered = 0;
		while (voices_offered < RANDOM_ITEMS) begin
			len = frame_length();
			steady = (frame % 25) < 3;
			if (frame == 3)
				long_hold_req = 1'b1;
			for (k = 0; k < len; k++)
				offer_voice(random_voice(k == len - 1), 1'b0, '0);
			frame++;
		end
		steady = 1'b0;
		voice_valid <= 1'b0;

		drain = 0;
		while (mix_due.size() > 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		if (mix_due.size() > 0) begin
			fails += mix_due.size();
			$display("%0t: %0d mix words never arrived", $time, mix_due.size());
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Closed %0d frames (%0d mix words taken): %0d past full scale,",
			frames_closed, mixes_seen, frames_clipped);
		$display("%0d over the voice limit; random part offered %0d voice words, %s",
			frames_overfull, voices_offered, "with gaps and a long output hold.");
		if (fails == 0)
			$display("** stereo_voice_mixer_soft_clip: PASSED **");
		else
			$display("** stereo_voice_mixer_soft_clip: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("%0t: run timed out", $time);
		$display("** stereo_voice_mixer_soft_clip: FAILED **");
		$finish;
	end

endmodule
